[hdl/assert_macros.svh]
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Checked on every rising clock edge outside reset.
`define VQNC_ASSERT(name, prop) \
   name: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("vqnc: check failed");

// Checked on every rising clock edge, reset included.
`define VQNC_ASSERT_NORST(name, prop) \
   name: assert property (@(posedge clock) prop) \
      else $error("vqnc: check failed");

`else

`define VQNC_ASSERT(name, prop)
`define VQNC_ASSERT_NORST(name, prop)

`endif

`endif

[hdl/vqnc_pkg.sv]
package vqnc_pkg;

   // Sizing
   localparam int MAX_CODEWORDS = 256;
   localparam int MAX_DIMS      = 16;
   localparam int CW_W          = (MAX_CODEWORDS > 1) ? $clog2(MAX_CODEWORDS) : 1;
   localparam int DIM_W         = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam int MEM_DEPTH     = MAX_CODEWORDS * MAX_DIMS;
   localparam int MEM_ADDR_W    = $clog2(MEM_DEPTH);

   // Field widths
   localparam int ENTRY_W   = 8;
   localparam int ELEMENT_W = 4;
   localparam int VALUE_W   = 16;
   localparam int WINNER_W  = 8;
   localparam int DIST_W    = 36;
   localparam int DIFF_W    = VALUE_W + 1;
   localparam int SQ_W      = 2 * DIFF_W;
   localparam int SUM_W     = DIST_W + 1;

   // Beat layout
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 48;

   // Configuration
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 9;
   localparam int CFG_CW_W   = 9;
   localparam int CFG_DIM_W  = 5;
   localparam int CFG_CW_RESET  = 256;
   localparam int CFG_DIM_RESET = 16;

   localparam logic [DIST_W-1:0] DIST_SAT = {DIST_W{1'b1}};

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CODEWORDS_USED = 1'b0,
      CSR_DIMS_USED      = 1'b1
   } vqnc_csr_type;

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_QUERY = 1'b1
   } vqnc_op_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WALK,
      ST_DRAIN,
      ST_PUT
   } vqnc_state_type;

   // One element step of the search, sequencer to distance unit
   typedef struct packed {
      logic             valid;
      logic             first;
      logic             last;
      logic             final_cw;
      logic [CW_W-1:0]  cw;
      logic [DIM_W-1:0] dim;
   } vqnc_step_type;

   // Query element store write
   typedef struct packed {
      logic               we;
      logic [DIM_W-1:0]   idx;
      logic [VALUE_W-1:0] value;
   } vqnc_qwr_type;

   // Codebook memory access
   typedef struct packed {
      logic                  we;
      logic [MEM_ADDR_W-1:0] waddr;
      logic [VALUE_W-1:0]    wdata;
      logic [MEM_ADDR_W-1:0] raddr;
   } vqnc_mem_type;

   // Search outcome
   typedef struct packed {
      logic              done;
      logic [CW_W-1:0]   winner;
      logic [DIST_W-1:0] distance;
   } vqnc_result_type;

endpackage

[hdl/vqnc_ram.sv]
module vqnc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[hdl/vqnc_dist.sv]
`include "assert_macros.svh"

module vqnc_dist (
   input  logic                           clock,
   input  logic                           reset,
   input  vqnc_pkg::vqnc_qwr_type         qwr,
   input  vqnc_pkg::vqnc_step_type        step,
   input  logic [vqnc_pkg::VALUE_W-1:0]   rd_data,
   output vqnc_pkg::vqnc_result_type      result
);

   import vqnc_pkg::*;

   logic [VALUE_W-1:0]        query_ff [MAX_DIMS];
   vqnc_step_type             step_d1_ff, step_d1_in;
   vqnc_step_type             step_d2_ff, step_d2_in;
   logic [VALUE_W-1:0]        q_d1_ff, q_d1_in;
   logic [SQ_W-1:0]           sq_ff, sq_in;
   logic [DIST_W-1:0]         acc_ff, acc_in;
   logic [CW_W-1:0]           best_cw_ff, best_cw_in;
   logic [DIST_W-1:0]         best_dist_ff, best_dist_in;
   logic                      done_ff, done_in;
   logic signed [DIFF_W-1:0]  diff;
   logic signed [SQ_W-1:0]    prod;
   logic [SUM_W-1:0]          sum;
   logic                      take;

   // Query element store, written while idle
   always_ff @(posedge clock) begin
      if (qwr.we) begin
         query_ff[qwr.idx] <= qwr.value;
      end
   end

   // Stage 1: codebook word arrives from RAM, query element alongside
   always_comb begin
      step_d1_in = step;
      q_d1_in    = query_ff[step.dim];
   end

   // Stage 2: difference and square
   always_comb begin
      diff       = $signed({rd_data[VALUE_W-1], rd_data})
                 - $signed({q_d1_ff[VALUE_W-1], q_d1_ff});
      prod       = diff * diff;
      sq_in      = $unsigned(prod);
      step_d2_in = step_d1_ff;
   end

   // Stage 3: saturating accumulate and best-so-far compare
   always_comb begin
      sum = (step_d2_ff.first ? '0 : {1'b0, acc_ff}) + SUM_W'(sq_ff);
      acc_in = acc_ff;
      if (step_d2_ff.valid) begin
         acc_in = sum[DIST_W] ? DIST_SAT : sum[DIST_W-1:0];
      end
      take = step_d2_ff.valid && step_d2_ff.last
          && (step_d2_ff.cw == '0 || acc_in < best_dist_ff);
      best_cw_in   = take ? step_d2_ff.cw : best_cw_ff;
      best_dist_in = take ? acc_in : best_dist_ff;
      done_in      = step_d2_ff.valid && step_d2_ff.last && step_d2_ff.final_cw;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_d1_ff <= '0;
         step_d2_ff <= '0;
         done_ff    <= 1'b0;
      end else begin
         step_d1_ff <= step_d1_in;
         step_d2_ff <= step_d2_in;
         done_ff    <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      q_d1_ff      <= q_d1_in;
      sq_ff        <= sq_in;
      acc_ff       <= acc_in;
      best_cw_ff   <= best_cw_in;
      best_dist_ff <= best_dist_in;
   end

   assign result.done     = done_ff;
   assign result.winner   = best_cw_ff;
   assign result.distance = best_dist_ff;

   // Elements of one codevector reach the accumulator back to back
   `VQNC_ASSERT(a_elems_contiguous, step_d2_ff.valid && !step_d2_ff.first |-> $past(step_d2_ff.valid))
   // One completion per search
   `VQNC_ASSERT(a_done_single, done_ff |=> !done_ff)

endmodule

[hdl/vqnc_seq.sv]
`include "assert_macros.svh"

module vqnc_seq (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [vqnc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [vqnc_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_op,
   input  logic [vqnc_pkg::ENTRY_W-1:0]      req_entry,
   input  logic [vqnc_pkg::ELEMENT_W-1:0]    req_element,
   input  logic [vqnc_pkg::VALUE_W-1:0]      req_value,
   input  logic                              req_last,
   input  logic                              rsp_free,
   input  logic                              walk_done,
   output vqnc_pkg::vqnc_mem_type            mem,
   output vqnc_pkg::vqnc_step_type           step,
   output vqnc_pkg::vqnc_qwr_type            qwr,
   output logic                              rsp_load
);

   import vqnc_pkg::*;

   vqnc_state_type         state_ff, state_in;
   logic [MEM_ADDR_W-1:0]  clr_ff, clr_in;
   logic [CW_W-1:0]        cw_ff, cw_in;
   logic [DIM_W-1:0]       dim_ff, dim_in;
   logic [CFG_CW_W-1:0]    cw_cfg_ff, cw_cfg_in;
   logic [CFG_DIM_W-1:0]   dim_cfg_ff, dim_cfg_in;
   logic [CW_W-1:0]        cw_last;
   logic [DIM_W-1:0]       dim_last;
   logic                   accept;
   logic                   is_query;
   logic                   wr_in_range;
   logic                   walk_end;

   // Configuration registers
   always_comb begin
      cw_cfg_in  = cw_cfg_ff;
      dim_cfg_in = dim_cfg_ff;
      if (csr_we) begin
         unique case (vqnc_csr_type'(csr_index))
            CSR_CODEWORDS_USED: cw_cfg_in  = csr_wdata[CFG_CW_W-1:0];
            CSR_DIMS_USED:      dim_cfg_in = csr_wdata[CFG_DIM_W-1:0];
         endcase
      end
   end

   // Clamp counts to 1..max, kept as last index
   always_comb begin
      int n;
      int d;
      n = int'(cw_cfg_ff);
      d = int'(dim_cfg_ff);
      if (n < 1) n = 1;
      if (n > MAX_CODEWORDS) n = MAX_CODEWORDS;
      if (d < 1) d = 1;
      if (d > MAX_DIMS) d = MAX_DIMS;
      cw_last  = CW_W'(n - 1);
      dim_last = DIM_W'(d - 1);
   end

   assign accept      = req_valid && req_ready;
   assign is_query    = vqnc_op_type'(req_op) == OP_QUERY;
   assign wr_in_range = int'(req_entry) < MAX_CODEWORDS && int'(req_element) < MAX_DIMS;
   assign walk_end    = cw_ff == cw_last && dim_ff == dim_last;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (clr_ff == MEM_ADDR_W'(MEM_DEPTH - 1)) state_in = ST_IDLE;
         ST_IDLE:  if (accept && is_query && req_last) state_in = ST_WALK;
         ST_WALK:  if (walk_end) state_in = ST_DRAIN;
         ST_DRAIN: if (walk_done) state_in = ST_PUT;
         ST_PUT:   if (rsp_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Clear address and walk counters
   always_comb begin
      clr_in = clr_ff;
      cw_in  = cw_ff;
      dim_in = dim_ff;
      unique case (state_ff)
         ST_CLEAR: clr_in = clr_ff + 1'b1;
         ST_IDLE: begin
            cw_in  = '0;
            dim_in = '0;
         end
         ST_WALK: begin
            if (dim_ff == dim_last) begin
               dim_in = '0;
               cw_in  = cw_ff + 1'b1;
            end else begin
               dim_in = dim_ff + 1'b1;
            end
         end
         default: ;
      endcase
   end

   // Outputs
   always_comb begin
      req_ready     = 1'b0;
      mem.we        = 1'b0;
      mem.waddr     = MEM_ADDR_W'(MEM_ADDR_W'(req_entry) * MEM_ADDR_W'(MAX_DIMS)
                    + MEM_ADDR_W'(req_element));
      mem.wdata     = req_value;
      mem.raddr     = MEM_ADDR_W'(MEM_ADDR_W'(cw_ff) * MEM_ADDR_W'(MAX_DIMS)
                    + MEM_ADDR_W'(dim_ff));
      qwr.we        = 1'b0;
      qwr.idx       = DIM_W'(req_element);
      qwr.value     = req_value;
      step.valid    = 1'b0;
      step.first    = dim_ff == '0;
      step.last     = dim_ff == dim_last;
      step.final_cw = cw_ff == cw_last;
      step.cw       = cw_ff;
      step.dim      = dim_ff;
      rsp_load      = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            mem.we    = 1'b1;
            mem.waddr = clr_ff;
            mem.wdata = '0;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            mem.we    = accept && !is_query && wr_in_range;
            qwr.we    = accept && is_query && int'(req_element) < MAX_DIMS;
         end
         ST_WALK:  step.valid = 1'b1;
         ST_PUT:   rsp_load   = rsp_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_ff     <= '0;
         cw_ff      <= '0;
         dim_ff     <= '0;
         cw_cfg_ff  <= CFG_CW_W'(CFG_CW_RESET);
         dim_cfg_ff <= CFG_DIM_W'(CFG_DIM_RESET);
      end else begin
         state_ff   <= state_in;
         clr_ff     <= clr_in;
         cw_ff      <= cw_in;
         dim_ff     <= dim_in;
         cw_cfg_ff  <= cw_cfg_in;
         dim_cfg_ff <= dim_cfg_in;
      end
   end

   // The distance unit finishes only after the walk has been issued
   `VQNC_ASSERT(a_done_in_drain, $rose(walk_done) |-> state_ff == ST_DRAIN)
   // Element counter stays inside the active dimensions
   `VQNC_ASSERT_NORST(a_dim_bound, state_ff == ST_WALK |-> dim_ff <= dim_last)

endmodule

[hdl/vq_nearest_codevector.sv]
// Channel   Dir  Beat contents
// req_*     in   tuser: operation; tdata: entry, element, value; tlast: last
// rsp_*     out  tdata: winner, best_distance
// csr_*     in   write enable, register index, write data
//
// After reset a clearing pass zeroes the codebook RAM, one word a cycle;
// req_tready stays low meanwhile. A codebook write or a query element
// without last leaves the block ready for the next beat. A query element
// with last walks codewords_used * dims_used words through the single
// subtract/square/accumulate unit, one RAM word per cycle, then drains the
// pipeline and hands off the result; no item is taken during the search.
// A result waiting on rsp_tready holds the next search at its end, not the input.
module vq_nearest_codevector (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [vqnc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [vqnc_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [7:0] entry, [11:8] element, [27:12] value, [31:28] zero
   input  logic [vqnc_pkg::REQ_DATA_W-1:0]     req_tdata,
   // [0] operation
   input  logic                                req_tuser,
   input  logic                                req_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [7:0] winner, [43:8] best_distance, [47:44] zero
   output logic [vqnc_pkg::RSP_DATA_W-1:0]     rsp_tdata
);

   import vqnc_pkg::*;

   vqnc_mem_type           mem;
   vqnc_step_type          step;
   vqnc_qwr_type           qwr;
   vqnc_result_type        result;
   logic [VALUE_W-1:0]     rd_data;
   logic                   rsp_load;
   logic                   rsp_free;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]  rsp_data_ff, rsp_data_in;

   vqnc_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_op      (req_tuser),
      .req_entry   (req_tdata[ENTRY_W-1:0]),
      .req_element (req_tdata[ENTRY_W+ELEMENT_W-1:ENTRY_W]),
      .req_value   (req_tdata[ENTRY_W+ELEMENT_W+VALUE_W-1:ENTRY_W+ELEMENT_W]),
      .req_last    (req_tlast),
      .rsp_free    (rsp_free),
      .walk_done   (result.done),
      .mem         (mem),
      .step        (step),
      .qwr         (qwr),
      .rsp_load    (rsp_load)
   );

   vqnc_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (MEM_DEPTH)
   ) u_codebook (
      .clock (clock),
      .we    (mem.we),
      .waddr (mem.waddr),
      .wdata (mem.wdata),
      .raddr (mem.raddr),
      .rdata (rd_data)
   );

   vqnc_dist u_dist (
      .clock   (clock),
      .reset   (reset),
      .qwr     (qwr),
      .step    (step),
      .rd_data (rd_data),
      .result  (result)
   );

   // Output register
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = RSP_DATA_W'({result.distance, WINNER_W'(result.winner)});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

[bench/vq_nearest_codevector_tb.sv]
`timescale 1ns / 100ps

module vq_nearest_codevector_tb;
   import vqnc_pkg::*;

   // One request beat as the bench sees it
   typedef struct packed {
      vqnc_op_type               op;
      logic [ENTRY_W-1:0]        entry;
      logic [ELEMENT_W-1:0]      element;
      logic signed [VALUE_W-1:0] value;
      logic                      last;
   } vq_beat_type;

   // One search outcome
   typedef struct packed {
      logic [WINNER_W-1:0] winner;
      logic [DIST_W-1:0]   distance;
   } nearest_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  req_tlast = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   vq_nearest_codevector dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // Shadow of the block state and its registers
   logic signed [VALUE_W-1:0] codebook_mdl [MAX_CODEWORDS][MAX_DIMS];
   logic signed [VALUE_W-1:0] query_mdl [MAX_DIMS];
   logic [CFG_CW_W-1:0]       cfg_codewords = CFG_CW_W'(CFG_CW_RESET);
   logic [CFG_DIM_W-1:0]      cfg_dims = CFG_DIM_W'(CFG_DIM_RESET);

   // Last query values queued, used to aim codebook writes near the query
   logic signed [VALUE_W-1:0] gen_query [MAX_DIMS];

   vq_beat_type        pending_beats [$];
   nearest_result_type nearest_expected [$];
   vq_beat_type        req_cur;
   bit                 req_beat_taken = 1'b0;

   int items_queued = 0;
   int items_taken = 0;
   int searches_checked = 0;
   int settings_run = 1;
   int mismatches = 0;
   int sender_idle_pct = 0;
   int rsp_stall_pct = 0;

   function automatic int codewords_eff();
      if (cfg_codewords == 0) return 1;
      if (cfg_codewords > MAX_CODEWORDS) return MAX_CODEWORDS;
      return cfg_codewords;
   endfunction

   function automatic int dims_eff();
      if (cfg_dims == 0) return 1;
      if (cfg_dims > MAX_DIMS) return MAX_DIMS;
      return cfg_dims;
   endfunction

   // Exhaustive walk: squared distance per codevector, strict less-than keeps lowest index
   function automatic nearest_result_type find_nearest();
      int                  n, dims, cw, d, diff, best_cw;
      longint unsigned     sum, best_sum;
      nearest_result_type  res;
      n = codewords_eff();
      dims = dims_eff();
      best_cw = 0;
      best_sum = 0;
      for (cw = 0; cw < n; cw++) begin
         sum = 0;
         for (d = 0; d < dims; d++) begin
            diff = int'(codebook_mdl[cw][d]) - int'(query_mdl[d]);
            sum += longint'(diff) * longint'(diff);
            if (sum > DIST_SAT) sum = DIST_SAT;
         end
         if (cw == 0 || sum < best_sum) begin
            best_sum = sum;
            best_cw = cw;
         end
      end
      res.winner = best_cw[WINNER_W-1:0];
      res.distance = best_sum[DIST_W-1:0];
      return res;
   endfunction

   // Apply one accepted beat to the shadow state
   function automatic void absorb_beat(vq_beat_type b);
      if (b.op == OP_WRITE) begin
         if (b.entry < MAX_CODEWORDS && b.element < MAX_DIMS)
            codebook_mdl[b.entry][b.element] = b.value;
      end else begin
         if (b.element < MAX_DIMS) query_mdl[b.element] = b.value;
         if (b.last) nearest_expected = {nearest_expected, find_nearest()};
      end
   endfunction

   task automatic note_mismatch(input string what);
      mismatches++;
      if (mismatches <= 10) $display("%0t: %s", $realtime, what);
   endtask

   // Driver: next beat at the falling edge once the current one is taken
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_beat_taken) begin
         req_beat_taken = 1'b0;
         if (pending_beats.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
            req_cur = pending_beats.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= {4'b0, req_cur.value, req_cur.element, req_cur.entry};
            req_tuser <= req_cur.op;
            req_tlast <= req_cur.last;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Monitor: beats and results at the rising edge
   always @(posedge clock) begin
      nearest_result_type exp;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            req_beat_taken = 1'b1;
            items_taken++;
            absorb_beat(req_cur);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (nearest_expected.size() == 0) begin
               note_mismatch($sformatf("result with none pending: winner %0d distance %0d",
                                       rsp_tdata[7:0], rsp_tdata[43:8]));
            end else begin
               exp = nearest_expected.pop_front();
               searches_checked++;
               if (rsp_tdata[7:0] !== exp.winner || rsp_tdata[43:8] !== exp.distance)
                  note_mismatch($sformatf("winner %0d distance %0d, expected %0d / %0d",
                                          rsp_tdata[7:0], rsp_tdata[43:8],
                                          exp.winner, exp.distance));
            end
         end
      end
   end

   task automatic push_beat(input vqnc_op_type op, input int entry, input int element,
                            input int val, input bit last);
      vq_beat_type b;
      b.op = op;
      b.entry = entry[ENTRY_W-1:0];
      b.element = element[ELEMENT_W-1:0];
      b.value = val[VALUE_W-1:0];
      b.last = last;
      if (op == OP_QUERY) gen_query[b.element] = b.value;
      pending_beats = {pending_beats, b};
      items_queued++;
   endtask

   task automatic write_csr(input vqnc_csr_type idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      if (idx == CSR_CODEWORDS_USED) cfg_codewords = data[CFG_CW_W-1:0];
      else cfg_dims = data[CFG_DIM_W-1:0];
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Block is quiet: all beats taken, all results seen, pipeline drained
   task automatic wait_idle();
      while (items_taken != items_queued || nearest_expected.size() != 0)
         @(negedge clock);
      repeat (20) @(posedge clock);
   endtask

   // Feature value: extremes, near the current query, small, or anything
   function automatic int pick_value(input int el);
      int r;
      r = $urandom_range(99);
      if (r < 15) begin
         case ($urandom_range(3))
            0: return -32768;
            1: return 32767;
            2: return 0;
            default: return -1;
         endcase
      end
      if (r < 45) return int'(gen_query[el]) + int'($urandom_range(6)) - 3;
      if (r < 65) return int'($urandom_range(16)) - 8;
      return int'($urandom);
   endfunction

   // Mostly codebook bursts and whole queries, some stray query elements
   task automatic run_random_phase(input int cw_reg, input int dim_reg, input int count,
                                   input int idle_pct, input int stall_pct);
      int n, dims, made, kind, len, el;
      wait_idle();
      write_csr(CSR_CODEWORDS_USED, cw_reg[CSR_DATA_W-1:0]);
      write_csr(CSR_DIMS_USED, dim_reg[CSR_DATA_W-1:0]);
      settings_run++;
      sender_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      n = codewords_eff();
      dims = dims_eff();
      made = 0;
      while (made < count) begin
         kind = $urandom_range(99);
         if (kind < 45) begin
            len = $urandom_range(6, 1);
            repeat (len) begin
               el = ($urandom_range(4) != 0) ? $urandom_range(dims - 1) : $urandom_range(15);
               push_beat(OP_WRITE,
                         ($urandom_range(4) != 0) ? $urandom_range(n - 1) : $urandom_range(255),
                         el, pick_value(el), $urandom_range(9) == 0);
            end
            made += len;
         end else if (kind < 90) begin
            for (el = 0; el < dims; el++)
               push_beat(OP_QUERY, $urandom_range(255), el, pick_value(el), el == dims - 1);
            made += dims;
         end else begin
            el = $urandom_range(15);
            push_beat(OP_QUERY, $urandom_range(255), el, pick_value(el), $urandom_range(1));
            made++;
         end
      end
   endtask

   initial begin
      int i, j;
      for (i = 0; i < MAX_CODEWORDS; i++)
         for (j = 0; j < MAX_DIMS; j++) codebook_mdl[i][j] = '0;
      for (j = 0; j < MAX_DIMS; j++) begin
         query_mdl[j] = '0;
         gen_query[j] = '0;
      end
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Full query against the cleared codebook: all tie, index zero wins
      for (j = 0; j < MAX_DIMS; j++)
         push_beat(OP_QUERY, 0, j, (j == 0) ? -32768 : (j == 15) ? 32767 : 0, j == 15);
      // Exact copy at the top index; last on a write must do nothing
      push_beat(OP_WRITE, 255, 0, -32768, 1'b0);
      push_beat(OP_WRITE, 255, 15, 32767, 1'b1);
      push_beat(OP_QUERY, 0, 7, 0, 1'b1);
      // Second exact copy at a lower index: tie goes to it
      push_beat(OP_WRITE, 200, 0, -32768, 1'b0);
      push_beat(OP_WRITE, 200, 15, 32767, 1'b0);
      push_beat(OP_QUERY, 255, 15, 32767, 1'b1);

      // Zero register values clamp to one; widest single-element distance
      wait_idle();
      write_csr(CSR_CODEWORDS_USED, '0);
      write_csr(CSR_DIMS_USED, '0);
      settings_run++;
      push_beat(OP_WRITE, 0, 0, 32767, 1'b0);
      push_beat(OP_QUERY, 0, 0, -32768, 1'b1);

      run_random_phase(16, 4, 180, 69, 0);
      run_random_phase(0, 0, 100, 0, 69);
      run_random_phase(40, 8, 180, 21, 21);
      run_random_phase(3, 16, 120, 0, 0);
      run_random_phase(511, 9'h1FF, 60, 69, 0);
      run_random_phase(256, 2, 150, 0, 69);
      run_random_phase(7, 9'h0A3, 60, 21, 21);

      wait_idle();
      $display("%0d request beats over %0d register settings, %0d searches checked",
               items_taken, settings_run, searches_checked);
      if (mismatches == 0) begin
         $display("vq_nearest_codevector regression: pass");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("vq_nearest_codevector regression: fail");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #50_000_000;
      $display("timeout: %0d of %0d beats taken, %0d results pending",
               items_taken, items_queued, nearest_expected.size());
      $display("vq_nearest_codevector regression: fail");
      $finish;
   end

endmodule
